[hdl/m3i_pkg.sv]
// shared types and constants of the 3x3 matrix inverse
// no dependencies
package m3i_pkg;

  localparam int NUM_ENT = 9;

  typedef logic [3:0] ent_idx_t;

  // operand indexes of each cofactor, already transposed, as ab - cd
  localparam ent_idx_t COF_IDX [NUM_ENT][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  typedef struct packed {
    logic vld;
    logic sing;
  } m3i_ctl_t;

endpackage

[hdl/m3i_cofactor.sv]
// two pipeline stages: pairwise products, then the nine cofactors
// depends on m3i_pkg
module m3i_cofactor #(
  parameter int W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  m3i_pkg::m3i_ctl_t   ctl_i,
  input  logic signed [W-1:0] a_i [m3i_pkg::NUM_ENT],
  output m3i_pkg::m3i_ctl_t   ctl_o,
  output logic signed [W-1:0] arow_o [3],
  output logic signed [2*W:0] cof_o [m3i_pkg::NUM_ENT]
);
  import m3i_pkg::*;

  localparam int CW = 2 * W + 1;

  m3i_ctl_t            ctl_b_q, ctl_c_q;
  logic signed [2*W-1:0] prod_d [2*NUM_ENT];
  logic signed [2*W-1:0] prod_q [2*NUM_ENT];
  logic signed [W-1:0] arow_b_q [3];
  logic signed [W-1:0] arow_c_q [3];
  logic signed [CW-1:0] cof_q [NUM_ENT];

  always_comb begin
    for (int k = 0; k < NUM_ENT; k++) begin
      prod_d[2*k]   = a_i[COF_IDX[k][0]] * a_i[COF_IDX[k][1]];
      prod_d[2*k+1] = a_i[COF_IDX[k][2]] * a_i[COF_IDX[k][3]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_b_q <= '0;
      ctl_c_q <= '0;
    end else begin
      ctl_b_q <= ctl_i;
      ctl_c_q <= ctl_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    for (int i = 0; i < 3; i++) begin
      arow_b_q[i] <= a_i[i];
      arow_c_q[i] <= arow_b_q[i];
    end
    for (int k = 0; k < NUM_ENT; k++) begin
      cof_q[k] <= CW'(prod_q[2*k]) - CW'(prod_q[2*k+1]);
    end
  end

  assign ctl_o  = ctl_c_q;
  assign arow_o = arow_c_q;
  assign cof_o  = cof_q;

endmodule

[hdl/m3i_det.sv]
// three pipeline stages: determinant partial products, their sum,
// then magnitudes and signs for the dividers; depends on m3i_pkg
module m3i_det #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  m3i_pkg::m3i_ctl_t      ctl_i,
  input  logic signed [W-1:0]    arow_i [3],
  input  logic signed [2*W:0]    cof_i [m3i_pkg::NUM_ENT],
  output m3i_pkg::m3i_ctl_t      ctl_o,
  output logic [3*W+2:0]         dmag_o,
  output logic [2*W+2*F:0]       num_o [m3i_pkg::NUM_ENT],
  output logic [m3i_pkg::NUM_ENT-1:0] rneg_o
);
  import m3i_pkg::*;

  localparam int CW  = 2 * W + 1;
  localparam int DTW = 3 * W + 3;
  localparam int NW  = CW + 2 * F;

  m3i_ctl_t ctl_d_q, ctl_e_q, ctl_f_q;
  logic signed [CW-1:0]  pl_q [3];
  logic signed [CW-1:0]  ph_q [3];
  logic signed [CW-1:0]  cof_d_q [NUM_ENT];
  logic signed [CW-1:0]  cof_e_q [NUM_ENT];
  logic signed [DTW-1:0] det_d;
  logic signed [DTW-1:0] det_q;
  logic [DTW-1:0]        dmag_q;
  logic [NW-1:0]         num_q [NUM_ENT];
  logic [NUM_ENT-1:0]    rneg_q;
  logic [CW-1:0]         cmag [NUM_ENT];
  logic                  sing_d;

  always_comb begin
    det_d = '0;
    for (int i = 0; i < 3; i++) begin
      det_d = det_d + (DTW'(ph_q[i]) <<< W) + DTW'(pl_q[i]);
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_ENT; k++) begin
      cmag[k] = cof_e_q[k][CW-1] ? CW'(-cof_e_q[k]) : CW'(cof_e_q[k]);
    end
  end

  assign sing_d = (det_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_d_q <= '0;
      ctl_e_q <= '0;
      ctl_f_q <= '0;
    end else begin
      ctl_d_q <= ctl_i;
      ctl_e_q <= ctl_d_q;
      ctl_f_q <= '{vld: ctl_e_q.vld, sing: sing_d};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pl_q[i] <= CW'(arow_i[i]) * $signed({1'b0, cof_i[3*i][W-1:0]});
      ph_q[i] <= CW'(arow_i[i]) * $signed(cof_i[3*i][CW-1:W]);
    end
    cof_d_q <= cof_i;
    cof_e_q <= cof_d_q;
    det_q   <= det_d;
    dmag_q  <= det_q[DTW-1] ? DTW'(-det_q) : DTW'(det_q);
    for (int k = 0; k < NUM_ENT; k++) begin
      num_q[k]  <= NW'(cmag[k]) << (2 * F);
      rneg_q[k] <= cof_e_q[k][CW-1] ^ det_q[DTW-1];
    end
  end

  assign ctl_o  = ctl_f_q;
  assign dmag_o = dmag_q;
  assign num_o  = num_q;
  assign rneg_o = rneg_q;

endmodule

[hdl/m3i_div_stage.sv]
// one restoring division step: compare, subtract, set one quotient bit
// no dependencies
module m3i_div_stage #(
  parameter int EW    = 140,
  parameter int DTW   = 99,
  parameter int QW    = 32,
  parameter int SHIFT = 0
) (
  input  logic           clk_i,
  input  logic [EW-1:0]  rem_i,
  input  logic [DTW-1:0] dmag_i,
  input  logic [QW-1:0]  q_i,
  output logic [EW-1:0]  rem_o,
  output logic [DTW-1:0] dmag_o,
  output logic [QW-1:0]  q_o
);

  logic [EW-1:0]  div_s;
  logic           ge;
  logic [QW-1:0]  q_d;
  logic [EW-1:0]  rem_q;
  logic [DTW-1:0] dmag_q;
  logic [QW-1:0]  q_q;

  assign div_s = EW'(dmag_i) << SHIFT;
  assign ge    = (rem_i >= div_s);

  always_comb begin
    q_d        = q_i;
    q_d[SHIFT] = ge;
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= ge ? (rem_i - div_s) : rem_i;
    dmag_q <= dmag_i;
    q_q    <= q_d;
  end

  assign rem_o  = rem_q;
  assign dmag_o = dmag_q;
  assign q_o    = q_q;

endmodule

[hdl/m3i_divider.sv]
// nine pipelined restoring dividers, range check, saturation and output register
// depends on m3i_pkg and m3i_div_stage
module m3i_divider #(
  parameter int QW  = 32,
  parameter int DTW = 99,
  parameter int NW  = 97,
  parameter int EW  = 132
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  m3i_pkg::m3i_ctl_t           ctl_i,
  input  logic [DTW-1:0]              dmag_i,
  input  logic [NW-1:0]               num_i [m3i_pkg::NUM_ENT],
  input  logic [m3i_pkg::NUM_ENT-1:0] rneg_i,
  output m3i_pkg::m3i_ctl_t           ctl_o,
  output logic [QW-1:0]               r_o [m3i_pkg::NUM_ENT],
  output logic                        ovf_o
);
  import m3i_pkg::*;

  m3i_ctl_t ctl_q [QW+2];
  logic [NUM_ENT-1:0] ovf_l;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < QW + 2; s++) ctl_q[s] <= '0;
    end else begin
      ctl_q[0] <= ctl_i;
      for (int s = 1; s < QW + 2; s++) ctl_q[s] <= ctl_q[s-1];
    end
  end

  for (genvar e = 0; e < NUM_ENT; e++) begin : g_lane
    logic [EW-1:0]  rem0_q;
    logic [DTW-1:0] dm0_q;
    logic [EW-1:0]  rem_w [QW];
    logic [DTW-1:0] dm_w [QW];
    logic [QW-1:0]  q_w [QW];
    logic [QW:0]    big_sr_q;
    logic [QW:0]    neg_sr_q;
    logic           big_d;
    logic [QW-1:0]  mag;
    logic [QW-1:0]  val;
    logic           ovf_d;
    logic [QW-1:0]  r_q;
    logic           ovf_q;

    assign big_d = (EW'(num_i[e]) >= (EW'(dmag_i) << QW));

    always_ff @(posedge clk_i) begin
      rem0_q   <= EW'(num_i[e]);
      dm0_q    <= dmag_i;
      big_sr_q <= {big_sr_q[QW-1:0], big_d};
      neg_sr_q <= {neg_sr_q[QW-1:0], rneg_i[e]};
    end

    for (genvar s = 0; s < QW; s++) begin : g_st
      if (s == 0) begin : g_first
        m3i_div_stage #(.EW(EW), .DTW(DTW), .QW(QW), .SHIFT(QW - 1)) u_stage (
          .clk_i  (clk_i),
          .rem_i  (rem0_q),
          .dmag_i (dm0_q),
          .q_i    ({QW{1'b0}}),
          .rem_o  (rem_w[0]),
          .dmag_o (dm_w[0]),
          .q_o    (q_w[0])
        );
      end else begin : g_next
        m3i_div_stage #(.EW(EW), .DTW(DTW), .QW(QW), .SHIFT(QW - 1 - s)) u_stage (
          .clk_i  (clk_i),
          .rem_i  (rem_w[s-1]),
          .dmag_i (dm_w[s-1]),
          .q_i    (q_w[s-1]),
          .rem_o  (rem_w[s]),
          .dmag_o (dm_w[s]),
          .q_o    (q_w[s])
        );
      end
    end

    // saturate to the signed range
    always_comb begin
      mag   = q_w[QW-1];
      ovf_d = 1'b0;
      if (!neg_sr_q[QW]) begin
        if (big_sr_q[QW] || mag[QW-1]) begin
          val   = {1'b0, {(QW-1){1'b1}}};
          ovf_d = 1'b1;
        end else begin
          val = mag;
        end
      end else begin
        if (big_sr_q[QW] || (mag[QW-1] && (|mag[QW-2:0]))) begin
          mag   = {1'b1, {(QW-1){1'b0}}};
          ovf_d = 1'b1;
        end
        val = ~mag + 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      r_q <= ctl_q[QW].sing ? '0 : val;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ovf_q <= 1'b0;
      end else begin
        ovf_q <= ctl_q[QW].vld & ~ctl_q[QW].sing & ovf_d;
      end
    end

    assign r_o[e]   = r_q;
    assign ovf_l[e] = ovf_q;
  end

  assign ctl_o = ctl_q[QW+1];
  assign ovf_o = |ovf_l;

endmodule

[hdl/matrix3_inverse.sv]
// 3x3 matrix inverse: input register, cofactors, determinant, nine dividers
// depends on m3i_pkg, m3i_cofactor, m3i_det, m3i_divider
// A matrix is taken with every start pulse; busy is always low, so one
// matrix can enter per cycle. Its inverse appears with done_o after one input
// register, two cofactor stages, three determinant stages, then a divider with
// an entry register, one stage per quotient bit and an output register after
// the range check. done_o lasts one cycle and cannot be held off.
module matrix3_inverse #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] a11_i,
  input  logic signed [DATA_WIDTH-1:0] a12_i,
  input  logic signed [DATA_WIDTH-1:0] a13_i,
  input  logic signed [DATA_WIDTH-1:0] a21_i,
  input  logic signed [DATA_WIDTH-1:0] a22_i,
  input  logic signed [DATA_WIDTH-1:0] a23_i,
  input  logic signed [DATA_WIDTH-1:0] a31_i,
  input  logic signed [DATA_WIDTH-1:0] a32_i,
  input  logic signed [DATA_WIDTH-1:0] a33_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] r11_o,
  output logic signed [DATA_WIDTH-1:0] r12_o,
  output logic signed [DATA_WIDTH-1:0] r13_o,
  output logic signed [DATA_WIDTH-1:0] r21_o,
  output logic signed [DATA_WIDTH-1:0] r22_o,
  output logic signed [DATA_WIDTH-1:0] r23_o,
  output logic signed [DATA_WIDTH-1:0] r31_o,
  output logic signed [DATA_WIDTH-1:0] r32_o,
  output logic signed [DATA_WIDTH-1:0] r33_o,
  output logic                         singular_o,
  output logic                         overflow_o
);
  import m3i_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int CW  = 2 * W + 1;
  localparam int DTW = 3 * W + 3;
  localparam int NW  = CW + 2 * FRAC_BITS;
  localparam int SW  = DTW + W;
  localparam int EW  = ((NW > SW) ? NW : SW) + 1;
  localparam int LAT = W + 8;

  m3i_ctl_t ctl_a_q, ctl_cof, ctl_det, ctl_out;
  logic signed [W-1:0]  a_q [NUM_ENT];
  logic signed [W-1:0]  arow [3];
  logic signed [CW-1:0] cof [NUM_ENT];
  logic [DTW-1:0]       dmag;
  logic [NW-1:0]        num [NUM_ENT];
  logic [NUM_ENT-1:0]   rneg;
  logic [W-1:0]         r [NUM_ENT];
  logic                 ovf;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
    end else begin
      ctl_a_q <= '{vld: start & ~busy, sing: 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= '{a11_i, a12_i, a13_i, a21_i, a22_i, a23_i, a31_i, a32_i, a33_i};
  end

  m3i_cofactor #(.W(W)) u_cof (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_a_q),
    .a_i    (a_q),
    .ctl_o  (ctl_cof),
    .arow_o (arow),
    .cof_o  (cof)
  );

  m3i_det #(.W(W), .F(FRAC_BITS)) u_det (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_cof),
    .arow_i (arow),
    .cof_i  (cof),
    .ctl_o  (ctl_det),
    .dmag_o (dmag),
    .num_o  (num),
    .rneg_o (rneg)
  );

  m3i_divider #(.QW(W), .DTW(DTW), .NW(NW), .EW(EW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_det),
    .dmag_i (dmag),
    .num_i  (num),
    .rneg_i (rneg),
    .ctl_o  (ctl_out),
    .r_o    (r),
    .ovf_o  (ovf)
  );

  assign done_o     = ctl_out.vld;
  assign singular_o = ctl_out.vld & ctl_out.sing;
  assign overflow_o = ovf;
  assign r11_o = $signed(r[0]);
  assign r12_o = $signed(r[1]);
  assign r13_o = $signed(r[2]);
  assign r21_o = $signed(r[3]);
  assign r22_o = $signed(r[4]);
  assign r23_o = $signed(r[5]);
  assign r31_o = $signed(r[6]);
  assign r32_o = $signed(r[7]);
  assign r33_o = $signed(r[8]);

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##LAT done_o) else $error("transfer lost in pipeline");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    singular_o |-> (r11_o == '0) && (r22_o == '0) && (r33_o == '0) && !overflow_o)
    else $error("singular result not cleared");

  a_flags_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> !singular_o && !overflow_o) else $error("flag without transfer");

endmodule
